// ----- design/uvs_pkg.sv -----
// ============================================================================
// UV sphere vertex generator package
// Shared widths, pipeline depths, register indexes and the sine/cosine
// result type passed between the top level and the angle pipeline.
// ============================================================================
package uvs_pkg;

  // Default largest grid side
  localparam int unsigned DEF_MAX_GRID_SIDE = 1024;

  // Width of the grid size registers and of the divisor
  localparam int unsigned SIDE_W = 11;

  // Quotient bits produced by the restoring divider and bits per stage
  localparam int unsigned QUO_W      = 42;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;

  // Angle pipeline: reduce, scale, square, six Horner terms, sine product,
  // then the quadrant select register
  localparam int unsigned ANG_STAGES = 22;
  localparam int unsigned ANG_DEPTH  = ANG_STAGES + 1;

  // Input register, divider, angle pipeline, product stage, output register
  localparam int unsigned PIPE_DEPTH = DIV_STAGES + ANG_DEPTH + 3;

  // Configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Sine and cosine as sign and Q30 magnitude
  typedef struct packed {
    logic        sn_neg;
    logic [30:0] sn_mag;
    logic        cs_neg;
    logic [30:0] cs_mag;
  } sc_t;

endpackage

// ----- design/uv_sphere_mesh_generator_unit.sv -----
// ============================================================================
// UV sphere vertex generator
// Turns a latitude-longitude grid point into its unit-sphere position,
// texture coordinates and, where the point starts a quad, six triangle indices.
// ============================================================================
// Usage:
//   Grid points enter on in_column/in_row with in_valid/in_ready; results
//   leave on the out_ ports with out_valid/out_ready. grid_width (index 0)
//   and grid_height (index 1) are written through cfg_we/cfg_index/cfg_data
//   while no item is in flight; values below 2 act as 2 and values above
//   MAX_GRID_SIDE act as MAX_GRID_SIDE.
//   One item is taken per cycle unless the output stalls: the longitude
//   and latitude quotients come from a 21-stage restoring divider (two
//   quotient bits a stage), and each of the six Horner terms of sine and
//   cosine takes three stages (multiply, reciprocal estimate, correction).
//   Reset clears the valid bits and loads width 64 and height 32.
//   When out_valid is high and out_ready low, the whole pipeline holds; the
//   input register still takes one item while it is empty.
// ============================================================================
module uv_sphere_mesh_generator_unit
  import uvs_pkg::*;
#(
  parameter int unsigned MAX_GRID_SIDE = DEF_MAX_GRID_SIDE
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          in_column,
  input  logic [9:0]          in_row,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_pos_x,
  output logic signed [15:0]  out_pos_y,
  output logic signed [15:0]  out_pos_z,
  output logic [15:0]         out_tex_u,
  output logic [15:0]         out_tex_v,
  output logic                out_quad_valid,
  output logic [19:0]         out_tri_one_a,
  output logic [19:0]         out_tri_one_b,
  output logic [19:0]         out_tri_one_c,
  output logic [19:0]         out_tri_two_a,
  output logic [19:0]         out_tri_two_b,
  output logic [19:0]         out_tri_two_c,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [SIDE_W-1:0]   cfg_data
);

  localparam logic [SIDE_W-1:0] SIDE_CAP = (MAX_GRID_SIDE >= (1 << SIDE_W)) ?
                                           {SIDE_W{1'b1}} : SIDE_W'(MAX_GRID_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_MIN = SIDE_W'(2);
  localparam int unsigned SIDE_N  = PIPE_DEPTH - 2;
  localparam int unsigned TEX_POS = DIV_STAGES;

  typedef struct packed {
    logic [SIDE_W-1:0] rem;
    logic [QUO_W-1:0]  nq;
  } div_t;

  typedef struct packed {
    logic        qv;
    logic [19:0] a;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
  } sd_t;

  logic [SIDE_W-1:0]   grid_width_r;
  logic [SIDE_W-1:0]   grid_height_r;
  logic [SIDE_W-1:0]   w_eff;
  logic [SIDE_W-1:0]   h_eff;
  logic [PIPE_DEPTH-1:0] v_r;
  logic                adv;

  logic [9:0]          col0_r;
  logic [9:0]          row0_r;
  logic                qv0_r;
  logic                qv0_nxt;

  div_t                dlon_r   [DIV_STAGES];
  div_t                dlat_r   [DIV_STAGES];
  div_t                dlon_nxt [DIV_STAGES];
  div_t                dlat_nxt [DIV_STAGES];
  sd_t                 side_r   [SIDE_N];
  sd_t                 side_nxt [SIDE_N];

  logic [QUO_W-1:0]    qlon;
  logic [QUO_W-1:0]    qlat;
  logic [31:0]         lon_turn;
  logic [31:0]         lat_turn;
  sc_t                 lat_sc;
  sc_t                 lon_sc;

  logic [61:0]         xm_r, xm_nxt;
  logic [61:0]         ym_r, ym_nxt;
  logic                xn_r, yn_r;
  logic [30:0]         zm_r;
  logic                zn_r;

  logic [15:0]         pos_x_r, pos_y_r, pos_z_r;
  logic [15:0]         pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [15:0]         tex_u_r, tex_v_r;
  logic                quad_valid_r;
  logic [19:0]         tri_a_r, tri_b_r, tri_c_r, tri_d_r;
  logic [19:0]         tri_a_nxt, tri_b_nxt, tri_c_nxt, tri_d_nxt;

  // Clamp a grid size register to the supported range.
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    if (v < SIDE_MIN) begin
      return SIDE_MIN;
    end else if (v > SIDE_CAP) begin
      return SIDE_CAP;
    end
    return v;
  endfunction

  // One restoring division step: shift in a numerator bit, subtract if it fits.
  function automatic div_t div_step(input div_t d, input logic [SIDE_W-1:0] dv);
    logic [SIDE_W:0] rem2;
    logic            qbit;
    div_t            r;
    rem2   = {d.rem, d.nq[QUO_W-1]};
    qbit   = (rem2 >= {1'b0, dv});
    r.rem  = qbit ? SIDE_W'(rem2 - {1'b0, dv}) : rem2[SIDE_W-1:0];
    r.nq   = {d.nq[QUO_W-2:0], qbit};
    return r;
  endfunction

  // Saturate a magnitude, rounded from Q60 or Q30, to Q15 and apply the sign.
  function automatic logic [15:0] sat16(input logic [16:0] m, input logic neg);
    logic [16:0] mm;
    if (neg) begin
      mm = (m > 17'd32768) ? 17'd32768 : m;
      mm = 17'd0 - mm;
      return mm[15:0];
    end
    return (m > 17'd32767) ? 16'h7FFF : m[15:0];
  endfunction

  assign w_eff = eff_side(grid_width_r);
  assign h_eff = eff_side(grid_height_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= SIDE_W'(64);
      grid_height_r <= SIDE_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: everything moves together unless the output item waits; an empty input register still loads.
  assign adv       = !v_r[PIPE_DEPTH-1] || out_ready;
  assign in_ready  = adv || !v_r[0];
  assign out_valid = v_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (in_ready) begin
        v_r[0] <= in_valid;
      end
      if (adv) begin
        v_r[PIPE_DEPTH-1:1] <= v_r[PIPE_DEPTH-2:0];
      end
    end
  end

  // Quad test at entry.
  assign qv0_nxt = (({1'b0, in_column} + SIDE_W'(1)) < w_eff) &&
                   (({1'b0, in_row} + SIDE_W'(1)) < h_eff);

  always_ff @(posedge clk) begin
    if (in_ready) begin
      col0_r <= in_column;
      row0_r <= in_row;
      qv0_r  <= qv0_nxt;
    end
  end

  // Divider stages for longitude and latitude.
  always_comb begin
    div_t src_lon;
    div_t src_lat;
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        src_lon.rem = '0;
        src_lon.nq  = {col0_r, 32'b0};
        src_lat.rem = '0;
        src_lat.nq  = {1'b0, row0_r, 31'b0};
      end else begin
        src_lon = dlon_r[(i == 0) ? 0 : i-1];
        src_lat = dlat_r[(i == 0) ? 0 : i-1];
      end
      for (int s = 0; s < DIV_STEPS; s++) begin
        src_lon = div_step(src_lon, w_eff);
        src_lat = div_step(src_lat, h_eff);
      end
      dlon_nxt[i] = src_lon;
      dlat_nxt[i] = src_lat;
    end
  end

  // Quotients to turn angles and texture coordinates.
  assign qlon     = dlon_r[DIV_STAGES-1].nq;
  assign qlat     = dlat_r[DIV_STAGES-1].nq;
  assign lon_turn = qlon[31:0] + 32'h8000_0000;
  assign lat_turn = qlat[31:0] + 32'hC000_0000;

  // Side data: base index, quad flag and texture coordinates.
  always_comb begin
    logic [20:0] rw;
    rw                = {11'b0, row0_r} * {10'b0, w_eff};
    side_nxt[0]       = '0;
    side_nxt[0].qv    = qv0_r;
    side_nxt[0].a     = rw[19:0] + {10'b0, col0_r};
    for (int i = 1; i < SIDE_N; i++) begin
      side_nxt[i] = side_r[i-1];
    end
    side_nxt[TEX_POS].tex_u = (|qlon[QUO_W-1:32]) ? 16'hFFFF : qlon[31:16];
    side_nxt[TEX_POS].tex_v = (|qlat[QUO_W-1:31]) ? 16'hFFFF : qlat[30:15];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        dlon_r[i] <= dlon_nxt[i];
        dlat_r[i] <= dlat_nxt[i];
      end
      for (int i = 0; i < SIDE_N; i++) begin
        side_r[i] <= side_nxt[i];
      end
    end
  end

  // Sine and cosine of both angles.
  uvs_sincos u_lat_sc (
    .clk  (clk),
    .en   (adv),
    .turn (lat_turn),
    .sc   (lat_sc)
  );

  uvs_sincos u_lon_sc (
    .clk  (clk),
    .en   (adv),
    .turn (lon_turn),
    .sc   (lon_sc)
  );

  // Position products.
  assign xm_nxt = {31'b0, lat_sc.cs_mag} * {31'b0, lon_sc.cs_mag};
  assign ym_nxt = {31'b0, lat_sc.cs_mag} * {31'b0, lon_sc.sn_mag};

  always_ff @(posedge clk) begin
    if (adv) begin
      xm_r <= xm_nxt;
      ym_r <= ym_nxt;
      xn_r <= lat_sc.cs_neg ^ lon_sc.cs_neg;
      yn_r <= lat_sc.cs_neg ^ lon_sc.sn_neg;
      zm_r <= lat_sc.sn_mag;
      zn_r <= lat_sc.sn_neg;
    end
  end

  // Rounding to Q15 and the triangle indices.
  always_comb begin
    logic [61:0] sx;
    logic [61:0] sy;
    logic [31:0] sz;
    sx        = xm_r + (62'd1 << 44);
    sy        = ym_r + (62'd1 << 44);
    sz        = {1'b0, zm_r} + 32'h0000_4000;
    pos_x_nxt = sat16(sx[61:45], xn_r);
    pos_y_nxt = sat16(sy[61:45], yn_r);
    pos_z_nxt = sat16(sz[31:15], zn_r);

    tri_a_nxt = side_r[SIDE_N-1].a;
    tri_b_nxt = side_r[SIDE_N-1].a + 20'd1;
    tri_c_nxt = side_r[SIDE_N-1].a + {9'b0, w_eff};
    tri_d_nxt = tri_c_nxt + 20'd1;
    if (!side_r[SIDE_N-1].qv) begin
      tri_a_nxt = '0;
      tri_b_nxt = '0;
      tri_c_nxt = '0;
      tri_d_nxt = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
      pos_z_r      <= pos_z_nxt;
      tex_u_r      <= side_r[SIDE_N-1].tex_u;
      tex_v_r      <= side_r[SIDE_N-1].tex_v;
      quad_valid_r <= side_r[SIDE_N-1].qv;
      tri_a_r      <= tri_a_nxt;
      tri_b_r      <= tri_b_nxt;
      tri_c_r      <= tri_c_nxt;
      tri_d_r      <= tri_d_nxt;
    end
  end

  assign out_pos_x      = pos_x_r;
  assign out_pos_y      = pos_y_r;
  assign out_pos_z      = pos_z_r;
  assign out_tex_u      = tex_u_r;
  assign out_tex_v      = tex_v_r;
  assign out_quad_valid = quad_valid_r;
  assign out_tri_one_a  = tri_a_r;
  assign out_tri_one_b  = tri_b_r;
  assign out_tri_one_c  = tri_c_r;
  assign out_tri_two_a  = tri_c_r;
  assign out_tri_two_b  = tri_d_r;
  assign out_tri_two_c  = tri_b_r;

endmodule

// ----- design/uvs_sincos.sv -----
// ============================================================================
// UV sphere angle pipeline
// Fixed-point sine and cosine of a 32-bit turn angle: octant reduction,
// scaling to radians, Horner evaluation with reciprocal division, and the
// quadrant sign selection. Every stage advances on the shared enable.
// ============================================================================
module uvs_sincos
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] turn,
  output sc_t         sc
);

  localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [29:0] OCTANT  = 30'h2000_0000;

  localparam int unsigned NUM_TERMS    = 6;
  localparam int unsigned TERM_STAGES  = 3;
  localparam int unsigned HORNER_FIRST = 3;
  localparam int unsigned SINE_STAGE   = HORNER_FIRST + NUM_TERMS * TERM_STAGES;

  localparam logic [7:0] SIN_DIV [NUM_TERMS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [NUM_TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  localparam logic [31:0] SIN_RECIP [NUM_TERMS] = '{
    32'((64'd1 << 32) / 64'd156), 32'((64'd1 << 32) / 64'd110),
    32'((64'd1 << 32) / 64'd72),  32'((64'd1 << 32) / 64'd42),
    32'((64'd1 << 32) / 64'd20),  32'((64'd1 << 32) / 64'd6)};
  localparam logic [31:0] COS_RECIP [NUM_TERMS] = '{
    32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)};

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] ts;
    logic [30:0] tc;
    logic [29:0] ps;
    logic [29:0] pc;
    logic [29:0] qs;
    logic [29:0] qc;
  } ang_t;

  ang_t ang_r   [ANG_STAGES];
  ang_t ang_nxt [ANG_STAGES];
  sc_t  sc_r;
  sc_t  sc_nxt;

  // Q30 product: a times b, scaled back by 2^30.
  function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
    logic [60:0] p;
    p = {31'b0, a} * {30'b0, b};
    return p[59:30];
  endfunction

  // Quotient estimate by reciprocal; it is exact or one low.
  function automatic logic [29:0] div_est(input logic [29:0] p, input logic [31:0] recip);
    logic [61:0] m;
    m = {32'b0, p} * {30'b0, recip};
    return m[61:32];
  endfunction

  // Correct the estimate and form the next Horner term, one minus the quotient.
  function automatic logic [30:0] horner_fix(input logic [29:0] p, input logic [29:0] q,
                                             input logic [7:0] k);
    logic [37:0] qk;
    logic [29:0] rem;
    logic [29:0] qf;
    qk  = {8'b0, q} * {30'b0, k};
    rem = p - qk[29:0];
    qf  = (rem >= {22'b0, k}) ? q + 30'd1 : q;
    return ONE_Q30 - {1'b0, qf};
  endfunction

  // Angle stages
  always_comb begin
    logic [61:0] scl;
    // Octant reduction; above an eighth of a turn sine and cosine trade places.
    ang_nxt[0]      = '0;
    ang_nxt[0].quad = turn[31:30];
    if (turn[29:0] >= OCTANT) begin
      ang_nxt[0].x    = 30'(ONE_Q30 - {1'b0, turn[29:0]});
      ang_nxt[0].swap = 1'b1;
    end else begin
      ang_nxt[0].x = turn[29:0];
    end

    for (int k = 1; k < ANG_STAGES; k++) begin
      ang_nxt[k] = ang_r[k-1];
    end

    // Turn fraction to radians in Q30.
    scl            = {32'b0, ang_r[0].x} * {30'b0, PI_Q30};
    ang_nxt[1].x   = scl[60:31];

    // Square of the angle; both series start at one.
    ang_nxt[2].x2  = mul_q30(ang_r[1].x, {1'b0, ang_r[1].x});
    ang_nxt[2].ts  = ONE_Q30;
    ang_nxt[2].tc  = ONE_Q30;

    // Horner terms: multiply, estimate quotient, correct.
    for (int j = 0; j < NUM_TERMS; j++) begin
      ang_nxt[HORNER_FIRST + TERM_STAGES*j].ps =
        mul_q30(ang_r[HORNER_FIRST + TERM_STAGES*j - 1].x2,
                ang_r[HORNER_FIRST + TERM_STAGES*j - 1].ts);
      ang_nxt[HORNER_FIRST + TERM_STAGES*j].pc =
        mul_q30(ang_r[HORNER_FIRST + TERM_STAGES*j - 1].x2,
                ang_r[HORNER_FIRST + TERM_STAGES*j - 1].tc);

      ang_nxt[HORNER_FIRST + TERM_STAGES*j + 1].qs =
        div_est(ang_r[HORNER_FIRST + TERM_STAGES*j].ps, SIN_RECIP[j]);
      ang_nxt[HORNER_FIRST + TERM_STAGES*j + 1].qc =
        div_est(ang_r[HORNER_FIRST + TERM_STAGES*j].pc, COS_RECIP[j]);

      ang_nxt[HORNER_FIRST + TERM_STAGES*j + 2].ts =
        horner_fix(ang_r[HORNER_FIRST + TERM_STAGES*j + 1].ps,
                   ang_r[HORNER_FIRST + TERM_STAGES*j + 1].qs, SIN_DIV[j]);
      ang_nxt[HORNER_FIRST + TERM_STAGES*j + 2].tc =
        horner_fix(ang_r[HORNER_FIRST + TERM_STAGES*j + 1].pc,
                   ang_r[HORNER_FIRST + TERM_STAGES*j + 1].qc, COS_DIV[j]);
    end

    // Sine is the angle times its series.
    ang_nxt[SINE_STAGE].ts = {1'b0, mul_q30(ang_r[SINE_STAGE-1].x, ang_r[SINE_STAGE-1].ts)};
  end

  // Undo the octant swap and apply the quadrant signs.
  always_comb begin
    logic [30:0] s;
    logic [30:0] c;
    if (ang_r[ANG_STAGES-1].swap) begin
      s = ang_r[ANG_STAGES-1].tc;
      c = ang_r[ANG_STAGES-1].ts;
    end else begin
      s = ang_r[ANG_STAGES-1].ts;
      c = ang_r[ANG_STAGES-1].tc;
    end
    sc_nxt = '0;
    case (ang_r[ANG_STAGES-1].quad)
      QUAD_FIRST: begin
        sc_nxt.sn_mag = s;  sc_nxt.cs_mag = c;
      end
      QUAD_SECOND: begin
        sc_nxt.sn_mag = c;  sc_nxt.cs_mag = s;  sc_nxt.cs_neg = 1'b1;
      end
      QUAD_THIRD: begin
        sc_nxt.sn_mag = s;  sc_nxt.sn_neg = 1'b1;
        sc_nxt.cs_mag = c;  sc_nxt.cs_neg = 1'b1;
      end
      QUAD_FOURTH: begin
        sc_nxt.sn_mag = c;  sc_nxt.sn_neg = 1'b1;  sc_nxt.cs_mag = s;
      end
      default: begin
        sc_nxt = '0;
      end
    endcase
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ANG_STAGES; k++) begin
        ang_r[k] <= ang_nxt[k];
      end
      sc_r <= sc_nxt;
    end
  end

  assign sc = sc_r;

endmodule

// ----- tb/sv/uv_sphere_mesh_generator_unit_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// UV sphere vertex generator testbench
// Streams grid points through the generator under several grid sizes and
// random handshake pressure. Every result is compared field by field with
// typed-in values or an in-bench fixed-point model of the sphere position,
// texture coordinates and quad indices.
// ============================================================================
module uv_sphere_mesh_generator_unit_test;
  import uvs_pkg::*;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic [15:0]        u, v;
    logic               quad;
    logic [19:0]        tri_idx [6];
  } vertex_t;

  typedef struct {
    logic [9:0] col, row;
    bit         typed;
    vertex_t    want;
  } point_row_t;

  localparam logic [63:0] Q30_ONE = 64'h4000_0000;
  localparam logic [63:0] PI_Q30  = 64'hC90F_DAA2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [9:0] in_column = '0;
  logic [9:0] in_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z;
  logic [15:0] out_tex_u, out_tex_v;
  logic out_quad_valid;
  logic [19:0] out_tri_one_a, out_tri_one_b, out_tri_one_c;
  logic [19:0] out_tri_two_a, out_tri_two_b, out_tri_two_c;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_GRID_WIDTH;
  logic [SIDE_W-1:0] cfg_data = '0;

  // Bench copy of the grid registers, raw as written.
  logic [10:0] grid_w_reg = 11'd64;
  logic [10:0] grid_h_reg = 11'd32;

  vertex_t pending_vertices[$];
  vertex_t typed_vertices[$];
  int errors = 0;
  int points_sent = 0;
  int vertices_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  uv_sphere_mesh_generator_unit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Clamp a register to the supported grid side.
  function automatic logic [63:0] clamp_side(logic [10:0] v);
    if (v < 2) return 2;
    if (v > DEF_MAX_GRID_SIDE) return DEF_MAX_GRID_SIDE;
    return v;
  endfunction

  // Horner evaluation of the sine or cosine series in Q30.
  function automatic logic [63:0] series_q30(logic [63:0] x2, bit is_sine);
    logic [63:0] t;
    logic [63:0] k;
    t = Q30_ONE;
    for (int i = 0; i < 6; i++) begin
      if (is_sine) k = (i == 0) ? 156 : (i == 1) ? 110 : (i == 2) ? 72 :
                       (i == 3) ? 42 : (i == 4) ? 20 : 6;
      else k = (i == 0) ? 132 : (i == 1) ? 90 : (i == 2) ? 56 :
               (i == 3) ? 30 : (i == 4) ? 12 : 2;
      t = Q30_ONE - ((x2 * t) >> 30) / k;
    end
    return t;
  endfunction

  // Sine and cosine of an angle in turns (2^32 per turn), signed Q30.
  function automatic void turn_sin_cos(input logic [31:0] turn,
                                       output longint sn, output longint cs);
    logic [63:0] r, x, x2;
    longint s, c, tmp;
    r = turn[29:0];
    tmp = 0;
    if (r >= 64'h2000_0000) r = Q30_ONE - r;
    x = (r * PI_Q30) >> 31;
    x2 = (x * x) >> 30;
    s = longint'((x * series_q30(x2, 1'b1)) >> 30);
    c = longint'(series_q30(x2, 1'b0));
    if (turn[29:0] >= 30'h2000_0000) begin
      tmp = s; s = c; c = tmp;
    end
    case (turn[31:30])
      2'd0: begin sn = s;  cs = c;  end
      2'd1: begin sn = c;  cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  // Round a magnitude half up and saturate into signed Q1.15.
  function automatic logic [15:0] to_q15(logic [63:0] mag, bit neg, int shift);
    logic [63:0] m;
    m = (mag + (64'd1 << (shift - 1))) >> shift;
    if (neg) begin
      if (m > 32768) m = 32768;
      return 16'(64'd0 - m);
    end
    if (m > 32767) m = 32767;
    return m[15:0];
  endfunction

  function automatic logic [63:0] magnitude(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic [15:0] product_q15(longint a, longint b);
    return to_q15(magnitude(a) * magnitude(b), (a < 0) != (b < 0), 45);
  endfunction

  function automatic logic [15:0] tex_fraction(logic [63:0] idx, logic [63:0] side);
    logic [63:0] t;
    t = (idx << 16) / side;
    return t > 65535 ? 16'hFFFF : t[15:0];
  endfunction

  // Expected vertex for one grid point under the current grid size.
  function automatic vertex_t sphere_vertex(logic [9:0] col_in, logic [9:0] row_in);
    vertex_t vx;
    logic [63:0] w, h, col, row, a, c;
    logic [31:0] lon, lat;
    longint slat, clat, slon, clon;
    w = clamp_side(grid_w_reg);
    h = clamp_side(grid_h_reg);
    col = col_in;
    row = row_in;
    lon = 32'(((col << 32) / w) + 64'h8000_0000);
    lat = 32'(((row << 31) / h) + 64'hC000_0000);
    turn_sin_cos(lat, slat, clat);
    turn_sin_cos(lon, slon, clon);
    vx.x = product_q15(clat, clon);
    vx.y = product_q15(clat, slon);
    vx.z = to_q15(magnitude(slat), slat < 0, 15);
    vx.u = tex_fraction(col, w);
    vx.v = tex_fraction(row, h);
    vx.quad = (col + 1 < w) && (row + 1 < h);
    a = row * w + col;
    c = (row + 1) * w + col;
    if (vx.quad) begin
      vx.tri_idx[0] = a[19:0];
      vx.tri_idx[1] = 20'(a + 1);
      vx.tri_idx[2] = c[19:0];
      vx.tri_idx[3] = c[19:0];
      vx.tri_idx[4] = 20'(c + 1);
      vx.tri_idx[5] = 20'(a + 1);
    end else begin
      for (int i = 0; i < 6; i++) vx.tri_idx[i] = '0;
    end
    return vx;
  endfunction

  // Queue the expectation for each accepted item.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (typed_vertices.size() > 0) pending_vertices.push_back(typed_vertices.pop_front());
      else pending_vertices.push_back(sphere_vertex(in_column, in_row));
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    vertex_t w;
    logic [19:0] got_idx [6];
    if (rst_n && out_valid && out_ready) begin
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item", $time);
      end else begin
        w = pending_vertices.pop_front();
        got_idx = '{out_tri_one_a, out_tri_one_b, out_tri_one_c,
                    out_tri_two_a, out_tri_two_b, out_tri_two_c};
        if (out_pos_x !== w.x || out_pos_y !== w.y || out_pos_z !== w.z) begin
          errors++;
          $display("%0t: position expected (%0d,%0d,%0d) got (%0d,%0d,%0d)", $time,
                   w.x, w.y, w.z, out_pos_x, out_pos_y, out_pos_z);
        end
        if (out_tex_u !== w.u || out_tex_v !== w.v) begin
          errors++;
          $display("%0t: texcoord expected (%0d,%0d) got (%0d,%0d)", $time,
                   w.u, w.v, out_tex_u, out_tex_v);
        end
        if (out_quad_valid !== w.quad) begin
          errors++;
          $display("%0t: quad_valid expected %0b got %0b", $time, w.quad, out_quad_valid);
        end
        for (int i = 0; i < 6; i++) begin
          if (got_idx[i] !== w.tri_idx[i]) begin
            errors++;
            $display("%0t: triangle index %0d expected %0d got %0d", $time, i,
                     w.tri_idx[i], got_idx[i]);
          end
        end
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one item and wait for it to be taken, with a random gap first.
  task automatic send_point(logic [9:0] col, logic [9:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_column <= col;
    in_row    <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
  endtask

  // Let the pipeline drain fully before touching the grid registers.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_vertices.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_grid(logic idx, logic [10:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_GRID_WIDTH) grid_w_reg = value;
    else grid_h_reg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Directed points at reset size (64 x 32); fully known rows are typed in.
  point_row_t directed [$];

  initial begin
    vertex_t origin, equator;
    logic [10:0] widths [6];
    logic [10:0] heights [6];
    logic [63:0] w, h;
    origin.x = 0; origin.y = 0; origin.z = -16'sd32768;
    origin.u = 0; origin.v = 0; origin.quad = 1'b1;
    origin.tri_idx = '{0, 1, 64, 64, 65, 1};
    equator.x = 16'sd32767; equator.y = 0; equator.z = 0;
    equator.u = 16'd32768; equator.v = 16'd32768; equator.quad = 1'b1;
    equator.tri_idx = '{1056, 1057, 1120, 1120, 1121, 1057};
    directed = '{
      '{10'd0, 10'd0, 1'b1, origin},
      '{10'd32, 10'd16, 1'b1, equator},
      '{10'd63, 10'd0, 1'b0, origin},
      '{10'd62, 10'd30, 1'b0, origin},
      '{10'd0, 10'd31, 1'b0, origin},
      '{10'd63, 10'd31, 1'b0, origin},
      '{10'd64, 10'd32, 1'b0, origin},
      '{10'd1023, 10'd1023, 1'b0, origin},
      '{10'd1023, 10'd0, 1'b0, origin},
      '{10'd0, 10'd1023, 1'b0, origin},
      '{10'd16, 10'd8, 1'b0, origin},
      '{10'd48, 10'd24, 1'b0, origin},
      '{10'd8, 10'd4, 1'b0, origin},
      '{10'd341, 10'd682, 1'b0, origin},
      '{10'd682, 10'd341, 1'b0, origin},
      '{10'd512, 10'd512, 1'b0, origin}
    };
    // Grid sizes per phase: clamping below two and above the maximum included.
    widths  = '{11'd64, 11'd0, 11'd2047, 11'd1024, 11'd2, 11'd1};
    heights = '{11'd32, 11'd2047, 11'd1, 11'd1024, 11'd2, 11'd1025};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].typed) typed_vertices.push_back(directed[i].want);
      else typed_vertices.push_back(sphere_vertex(directed[i].col, directed[i].row));
      send_point(directed[i].col, directed[i].row);
    end

    for (int phase = 0; phase < 7; phase++) begin
      drain_pipeline();
      if (phase < 6) begin
        write_grid(REG_GRID_WIDTH, widths[phase]);
        write_grid(REG_GRID_HEIGHT, heights[phase]);
      end else begin
        write_grid(REG_GRID_WIDTH, 11'($urandom_range(2047)));
        write_grid(REG_GRID_HEIGHT, 11'($urandom_range(2047)));
      end
      send_idle_pct  = (phase < 2) ? 34 : (phase < 4) ? 67 : 0;
      recv_stall_pct = (phase < 2) ? 67 : (phase < 4) ? 34 : 0;
      w = clamp_side(grid_w_reg);
      h = clamp_side(grid_h_reg);
      for (int n = 0; n < 120; n++) begin
        // Hold off once per phase until everything has come back.
        if (n == 60) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_vertices.size() > 0) @(posedge clk);
        end
        if ($urandom_range(99) < 85)
          send_point(10'($urandom_range(w - 1)), 10'($urandom_range(h - 1)));
        else
          send_point(10'($urandom_range(1023)), 10'($urandom_range(1023)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_vertices.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d grid points over seven grid sizes and checked %0d vertices.",
             points_sent, vertices_seen);
    $display("Grid sizes covered clamping at both ends, with and without handshake stalls.");
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Timeout waiting for results");
    $display("Some tests failed");
    $finish;
  end

endmodule
